>>> rtl/core/fcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrc_pkg
// shared types, constants and the byte-wide crc-16 update for the framed
// crc-16 decoder
// ----------------------------------------------------------------------------
package fcrc_pkg;

    // frame layout
    localparam int BODY_BYTES  = 16;
    localparam int FRAME_BYTES = BODY_BYTES + 4;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = (BODY_BYTES > 1) ? $clog2(BODY_BYTES) : 1;

    localparam logic [CNT_W-1:0] POS_MAGIC_FIRST  = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_MAGIC_SECOND = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_VERSION      = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CRC_LOW      = CNT_W'(BODY_BYTES + 2);
    localparam logic [CNT_W-1:0] POS_CRC_HIGH     = CNT_W'(BODY_BYTES + 3);
    localparam logic [CNT_W-1:0] CNT_FULL         = CNT_W'(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST         = IDX_W'(BODY_BYTES - 1);

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_SHORT       = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] STATUS_CRC_ERROR   = 3'd3;
    localparam logic [2:0] STATUS_BAD_VERSION = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fcrc_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] body_byte;
        logic       body_valid;
        logic       run_last;
    } fcrc_out_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

>>> rtl/core/framed_crc16_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_crc16_decoder_unit
// checks a framed buffer (magic, body with version byte, crc-16) and replays
// the stored body on success or version mismatch
// ----------------------------------------------------------------------------
// usage
//   byte channel: one received byte per request, last_byte marks buffer end
//   result channel: status, body byte, body valid and run_last per request
//   cfg channel: register index and data, always ready, write while idle
// latency and throughput
//   bytes are taken one per cycle while no result run is pending
//   on the last byte the status is decided in the same cycle; the first
//   result is presented on the next cycle
//   error status: one result; ok or wrong version: BODY_BYTES results at one
//   per cycle while result_ready is high, each read from the body memory
//   byte_ready stays low from the last byte until the run_last result leaves
// reset
//   counters, flags and crc return to their start values, config registers to zero
//   the body memory is not cleared, it is only read after being filled
// stall
//   the result register holds its request while result_ready is low and the
//   next memory read is issued only when the current result is taken
// ----------------------------------------------------------------------------
module framed_crc16_decoder_unit
    import fcrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // received bytes
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  fcrc_in_t             byte_data,
    // status and body results
    output logic                 result_valid,
    input  logic                 result_ready,
    output fcrc_out_t            result_data,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    // controller states
    localparam logic ST_RECV = 1'b0;   // taking bytes of the buffer
    localparam logic ST_SEND = 1'b1;   // presenting the result run

    // configuration registers
    logic [7:0] magic_first_reg;
    logic [7:0] magic_second_reg;
    logic [7:0] expected_version_reg;

    // per-frame state
    logic             state_reg,      state_next;
    logic [CNT_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic             magic_good_reg, magic_good_next;
    logic [15:0]      crc_reg,        crc_next;
    logic [15:0]      rx_crc_reg,     rx_crc_next;
    logic [7:0]       version_reg,    version_next;

    // result run
    logic [2:0]       status_reg,     status_next;
    logic             emit_body_reg,  emit_body_next;
    logic [IDX_W-1:0] idx_reg,        idx_next;

    // body memory, one write and one registered read port
    logic [7:0]       body_mem [BODY_BYTES];
    logic [7:0]       rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic             byte_accept;
    logic             result_accept;
    logic [CNT_W-1:0] body_off;
    logic [15:0]      rx_crc_full;
    logic [2:0]       status_calc;

    assign cfg_ready     = 1'b1;
    assign byte_ready    = (state_reg == ST_RECV);
    assign result_valid  = (state_reg == ST_SEND);
    assign byte_accept   = byte_valid && byte_ready;
    assign result_accept = result_valid && result_ready;

    // body bytes land at frame position minus the two magic bytes
    assign body_off = bytes_seen_reg - CNT_W'(2);
    assign wr_addr  = body_off[IDX_W-1:0];

    // result payload comes straight from registers
    assign result_data.status     = status_reg;
    assign result_data.body_byte  = emit_body_reg ? rd_data_reg : 8'h00;
    assign result_data.body_valid = emit_body_reg;
    assign result_data.run_last   = emit_body_reg ? (idx_reg == IDX_LAST) : 1'b1;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg      <= 8'h00;
            magic_second_reg     <= 8'h00;
            expected_version_reg <= 8'h00;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAGIC_FIRST:      magic_first_reg      <= cfg_data;
                REG_MAGIC_SECOND:     magic_second_reg     <= cfg_data;
                REG_EXPECTED_VERSION: expected_version_reg <= cfg_data;
                default:              ;   // unknown index, write dropped
            endcase
        end
    end

    // received crc including the current byte when it is the high crc byte
    assign rx_crc_full = (bytes_seen_reg == POS_CRC_HIGH) ?
                         {byte_data.data_byte, rx_crc_reg[7:0]} : rx_crc_reg;

    // status priority: short, magic, crc, version, ok
    // the frame is complete once the high crc byte or a later one arrives,
    // so magic flag, body crc and version are already final in their registers
    always_comb
    begin
        if (bytes_seen_reg < POS_CRC_HIGH)
            status_calc = STATUS_SHORT;
        else if (!magic_good_reg)
            status_calc = STATUS_BAD_MAGIC;
        else if (rx_crc_full != crc_reg)
            status_calc = STATUS_CRC_ERROR;
        else if (version_reg != expected_version_reg)
            status_calc = STATUS_BAD_VERSION;
        else
            status_calc = STATUS_OK;
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        bytes_seen_next = bytes_seen_reg;
        magic_good_next = magic_good_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        version_next    = version_reg;
        status_next     = status_reg;
        emit_body_next  = emit_body_reg;
        idx_next        = idx_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        case (state_reg)
            ST_RECV:
            begin
                if (byte_accept)
                begin
                    if (bytes_seen_reg == POS_MAGIC_FIRST)
                    begin
                        if (byte_data.data_byte != magic_first_reg)
                            magic_good_next = 1'b0;
                    end
                    else if (bytes_seen_reg == POS_MAGIC_SECOND)
                    begin
                        if (byte_data.data_byte != magic_second_reg)
                            magic_good_next = 1'b0;
                    end
                    else if (bytes_seen_reg < POS_CRC_LOW)
                    begin
                        wr_en    = 1'b1;
                        crc_next = crc_update(crc_reg, byte_data.data_byte);
                        if (bytes_seen_reg == POS_VERSION)
                            version_next = byte_data.data_byte;
                    end
                    else if (bytes_seen_reg == POS_CRC_LOW)
                    begin
                        rx_crc_next = {rx_crc_reg[15:8], byte_data.data_byte};
                    end
                    else if (bytes_seen_reg == POS_CRC_HIGH)
                    begin
                        rx_crc_next = {byte_data.data_byte, rx_crc_reg[7:0]};
                    end

                    // count saturates at the frame length
                    if (bytes_seen_reg < CNT_FULL)
                        bytes_seen_next = bytes_seen_reg + CNT_W'(1);

                    if (byte_data.last_byte)
                    begin
                        status_next    = status_calc;
                        emit_body_next = (status_calc == STATUS_OK) ||
                                         (status_calc == STATUS_BAD_VERSION);
                        idx_next       = '0;
                        // first body byte fetched now, shown next cycle
                        rd_en          = 1'b1;
                        rd_addr        = '0;
                        state_next     = ST_SEND;
                        // frame state back to its start values
                        bytes_seen_next = '0;
                        magic_good_next = 1'b1;
                        crc_next        = CRC_INIT;
                        rx_crc_next     = 16'h0000;
                    end
                end
            end

            ST_SEND:
            begin
                if (result_accept)
                begin
                    if (emit_body_reg && (idx_reg != IDX_LAST))
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        state_next = ST_RECV;
                    end
                end
            end

            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // control and frame registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RECV;
            bytes_seen_reg <= '0;
            magic_good_reg <= 1'b1;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= 16'h0000;
            emit_body_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            bytes_seen_reg <= bytes_seen_next;
            magic_good_reg <= magic_good_next;
            crc_reg        <= crc_next;
            rx_crc_reg     <= rx_crc_next;
            emit_body_reg  <= emit_body_next;
            idx_reg        <= idx_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        version_reg <= version_next;
        status_reg  <= status_next;
    end

    // body memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            body_mem[wr_addr] <= byte_data.data_byte;
        if (rd_en)
            rd_data_reg <= body_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // never taking bytes while a result run is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_ready && result_valid))
        else $error("byte taken during result run");

    // the end of a run hands control back to the byte side
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_accept && result_data.run_last) |=> byte_ready)
        else $error("byte side not released after run_last");

    // body bytes only go out for ok or wrong version
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.body_valid) |->
        (result_data.status == STATUS_OK || result_data.status == STATUS_BAD_VERSION))
        else $error("body emitted for an error status");

    // byte count never passes the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_seen_reg <= CNT_FULL)
        else $error("byte count past frame length");
`endif

endmodule
